/* rtl/gcvs_pkg.sv */
// gcvs_pkg: shared types and codes for the GC victim block selector.
// Used by gcvs_scan_core, gc_victim_block_select_top, gcvs_victim_checker and testbench; no dependencies.
`default_nettype none

package gcvs_pkg;

    // Field widths fixed by the scan format
    localparam int BLK_W    = 4;
    localparam int PS_W     = 3;
    localparam int ERASE_W  = 16;
    localparam int CNT_W    = 6;
    localparam int STATUS_W = 2;

    // Reset value of the live-page limit
    localparam logic [CNT_W-1:0] MAX_LIVE_RESET = 6'd25;

    // Page state codes; codes 4..7 (pinned, pending, source-pinned, staged) disqualify a block
    localparam logic [PS_W-1:0] PS_FREE   = 3'd0;
    localparam logic [PS_W-1:0] PS_LIVE   = 3'd1;
    localparam logic [PS_W-1:0] PS_STALE  = 3'd2;
    localparam logic [PS_W-1:0] PS_ORPHAN = 3'd3;

    typedef enum logic [STATUS_W-1:0] {
        ST_VICTIM   = 2'd0,
        ST_NO_BLOCK = 2'd1,
        ST_NOTHING  = 2'd2,
        ST_TOO_LIVE = 2'd3
    } status_t;

    // One scan beat
    typedef struct packed {
        logic [BLK_W-1:0]   block_index;
        logic [PS_W-1:0]    page_state;
        logic               block_is_data;
        logic               block_is_full;
        logic [ERASE_W-1:0] erase_count;
        logic               last_page;
        logic               last_block;
    } item_t;

    // One result beat
    typedef struct packed {
        status_t            status;
        logic [BLK_W-1:0]   chosen_block;
        logic [CNT_W-1:0]   live_count;
        logic [CNT_W-1:0]   reclaim_count;
    } result_t;

endpackage : gcvs_pkg

`default_nettype wire

/* rtl/gcvs_scan_core.sv */
// gcvs_scan_core: per-page counters and best-candidate tracking, one beat per step.
// Depends on gcvs_pkg.
`default_nettype none

module gcvs_scan_core
    import gcvs_pkg::*;
#(
    parameter int NUM_BLOCKS      = 16,
    parameter int PAGES_PER_BLOCK = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire item_t            item,
    input  wire logic [CNT_W-1:0] max_live,
    output logic                  res_valid,
    output result_t               res
);

    localparam int CNT_MAX_I = (PAGES_PER_BLOCK < 63) ? PAGES_PER_BLOCK : 63;
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(CNT_MAX_I);
    localparam logic [7:0]       BLK_LIMIT = 8'(NUM_BLOCKS);

    logic [CNT_W-1:0]   cur_live_reg,    cur_live_next;
    logic [CNT_W-1:0]   cur_reclaim_reg, cur_reclaim_next;
    logic               cur_disq_reg,    cur_disq_next;
    logic               best_valid_reg,  best_valid_next;
    logic [BLK_W-1:0]   best_block_reg,  best_block_next;
    logic [CNT_W-1:0]   best_reclaim_reg, best_reclaim_next;
    logic [CNT_W-1:0]   best_live_reg,   best_live_next;
    logic [ERASE_W-1:0] best_erase_reg,  best_erase_next;

    // Counts including this page
    logic [CNT_W-1:0] live_upd, reclaim_upd;
    logic             disq_upd;
    logic             blk_end, eligible, take, upd;

    always_comb
    begin
        live_upd    = cur_live_reg;
        reclaim_upd = cur_reclaim_reg;
        disq_upd    = cur_disq_reg;
        case (item.page_state)
            PS_FREE:
            begin
            end
            PS_LIVE:
            begin
                if (cur_live_reg < CNT_MAX)
                    live_upd = cur_live_reg + CNT_W'(1);
            end
            PS_STALE, PS_ORPHAN:
            begin
                if (cur_reclaim_reg < CNT_MAX)
                    reclaim_upd = cur_reclaim_reg + CNT_W'(1);
            end
            default:
            begin
                disq_upd = 1'b1;
            end
        endcase
    end

    // Block-end judgement against the best so far
    always_comb
    begin
        blk_end  = item.last_page | item.last_block;
        eligible = item.block_is_data & item.block_is_full & ~disq_upd &
                   (8'(item.block_index) < BLK_LIMIT);
        take = ~best_valid_reg ||
               (reclaim_upd > best_reclaim_reg) ||
               (reclaim_upd == best_reclaim_reg && item.erase_count < best_erase_reg) ||
               (reclaim_upd == best_reclaim_reg && item.erase_count == best_erase_reg &&
                item.block_index < best_block_reg);
        upd = blk_end & eligible & take;

        best_valid_next   = upd ? 1'b1             : best_valid_reg;
        best_block_next   = upd ? item.block_index : best_block_reg;
        best_reclaim_next = upd ? reclaim_upd      : best_reclaim_reg;
        best_live_next    = upd ? live_upd         : best_live_reg;
        best_erase_next   = upd ? item.erase_count : best_erase_reg;

        cur_live_next    = blk_end ? '0   : live_upd;
        cur_reclaim_next = blk_end ? '0   : reclaim_upd;
        cur_disq_next    = blk_end ? 1'b0 : disq_upd;
    end

    // Scan-end result from the updated best
    always_comb
    begin
        res_valid = step & item.last_block;
        res       = '0;
        if (!best_valid_next)
            res.status = ST_NO_BLOCK;
        else if (best_reclaim_next == '0)
            res.status = ST_NOTHING;
        else if (best_live_next > max_live)
            res.status = ST_TOO_LIVE;
        else
        begin
            res.status        = ST_VICTIM;
            res.chosen_block  = best_block_next;
            res.live_count    = best_live_next;
            res.reclaim_count = best_reclaim_next;
        end
    end

    // State update; scan end clears everything
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_live_reg     <= '0;
            cur_reclaim_reg  <= '0;
            cur_disq_reg     <= 1'b0;
            best_valid_reg   <= 1'b0;
            best_block_reg   <= '0;
            best_reclaim_reg <= '0;
            best_live_reg    <= '0;
            best_erase_reg   <= '0;
        end
        else if (step)
        begin
            if (item.last_block)
            begin
                cur_live_reg     <= '0;
                cur_reclaim_reg  <= '0;
                cur_disq_reg     <= 1'b0;
                best_valid_reg   <= 1'b0;
                best_block_reg   <= '0;
                best_reclaim_reg <= '0;
                best_live_reg    <= '0;
                best_erase_reg   <= '0;
            end
            else
            begin
                cur_live_reg     <= cur_live_next;
                cur_reclaim_reg  <= cur_reclaim_next;
                cur_disq_reg     <= cur_disq_next;
                best_valid_reg   <= best_valid_next;
                best_block_reg   <= best_block_next;
                best_reclaim_reg <= best_reclaim_next;
                best_live_reg    <= best_live_next;
                best_erase_reg   <= best_erase_next;
            end
        end
    end

`ifndef ASSERT_OFF
    // Scan end leaves a clean slate
    a_scan_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last_block |=>
            !best_valid_reg && cur_live_reg == '0 && cur_reclaim_reg == '0)
        else $error("scan state not cleared after scan end");

    // Counters never pass the saturation point
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_live_reg <= CNT_MAX && cur_reclaim_reg <= CNT_MAX)
        else $error("page counter beyond saturation");

    // A reported victim has something to reclaim and fits the live limit
    a_victim_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == ST_VICTIM |->
            res.reclaim_count != '0 && res.live_count <= max_live)
        else $error("victim reported against selection rules");

    // Best candidate only moves at a block end
    a_best_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        step && !item.last_page && !item.last_block |=> $stable(best_valid_reg))
        else $error("best candidate changed mid-block");
`endif

endmodule : gcvs_scan_core

`default_nettype wire

/* rtl/gc_victim_block_select_top.sv */
// gc_victim_block_select_top: GC victim block selector, handshakes and config register.
// Depends on gcvs_pkg and gcvs_scan_core.
`default_nettype none

// Takes one page-state beat per cycle, while in_stall is low, from a block-ordered
// metadata scan and, on the beat flagged last_block, emits one result: the full
// data block with the most stale/orphan pages (ties: lower erase count, then lower
// index), or a status code. Each beat passes an input register and then one step of
// the counter/compare logic, which loads the output register. Sustained rate is one
// beat per clock while in_stall is low, set by the counter and best-candidate update.
// in_stall rises only when a scan-end beat waits on a result still stalled at the
// output. max_live is written over its own valid/ready port (always ready); the user
// must write it only while no scan is in flight, which the block itself does not
// enforce.
module gc_victim_block_select_top
    import gcvs_pkg::*;
#(
    parameter int NUM_BLOCKS      = 16,
    parameter int PAGES_PER_BLOCK = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [BLK_W-1:0]   block_index,
    input  wire logic [PS_W-1:0]    page_state,
    input  wire logic               block_is_data,
    input  wire logic               block_is_full,
    input  wire logic [ERASE_W-1:0] erase_count,
    input  wire logic               last_page,
    input  wire logic               last_block,

    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [STATUS_W-1:0]     status,
    output logic [BLK_W-1:0]        chosen_block,
    output logic [CNT_W-1:0]        live_count,
    output logic [CNT_W-1:0]        reclaim_count,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CNT_W-1:0]   max_live
);

    logic             s1_valid_reg;
    item_t            s1_item_reg;
    logic             out_valid_reg;
    result_t          out_res_reg;
    logic [CNT_W-1:0] max_live_reg;

    logic    accept, advance;
    item_t   in_item;
    logic    res_valid;
    result_t res;

    always_comb
    begin
        in_item.block_index   = block_index;
        in_item.page_state    = page_state;
        in_item.block_is_data = block_is_data;
        in_item.block_is_full = block_is_full;
        in_item.erase_count   = erase_count;
        in_item.last_page     = last_page;
        in_item.last_block    = last_block;
    end

    // Stage advances unless its result has nowhere to go
    assign advance  = s1_valid_reg &
                      (~s1_item_reg.last_block | ~out_valid_reg | ~out_stall);
    assign in_stall = s1_valid_reg & ~advance;
    assign accept   = in_valid & ~in_stall;

    gcvs_scan_core #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (s1_item_reg),
        .max_live  (max_live_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= in_item;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_res_reg <= res;
    end

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_live_reg <= MAX_LIVE_RESET;
        else if (cfg_valid)
            max_live_reg <= max_live;
    end

    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign status        = out_res_reg.status;
    assign chosen_block  = out_res_reg.chosen_block;
    assign live_count    = out_res_reg.live_count;
    assign reclaim_count = out_res_reg.reclaim_count;

`ifndef ASSERT_OFF
    // A new result never lands on an untaken one
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !out_valid_reg || !out_stall)
        else $error("result overwrote a stalled result");

    // Stalling the input only happens with a scan end pending behind the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s1_item_reg.last_block && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");

    // Every scan-end beat in the stage produces a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_item_reg.last_block |=> out_valid_reg)
        else $error("scan end produced no result");
`endif

endmodule : gc_victim_block_select_top

`default_nettype wire

/* tb/sv/gcvs_victim_checker.sv */
// gcvs_victim_checker: watches the scan, config and result channels of the GC victim selector,
// predicts the verdict of every scan and compares it with the result beats.
// Depends on gcvs_pkg for field widths, page-state and status codes and the beat structs.

module gcvs_victim_checker
    import gcvs_pkg::*;
#(
    parameter int NUM_BLOCKS      = 16,
    parameter int PAGES_PER_BLOCK = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [BLK_W-1:0]   block_index,
    input  wire logic [PS_W-1:0]    page_state,
    input  wire logic               block_is_data,
    input  wire logic               block_is_full,
    input  wire logic [ERASE_W-1:0] erase_count,
    input  wire logic               last_page,
    input  wire logic               last_block,

    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [STATUS_W-1:0] status,
    input  wire logic [BLK_W-1:0]   chosen_block,
    input  wire logic [CNT_W-1:0]   live_count,
    input  wire logic [CNT_W-1:0]   reclaim_count,

    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [CNT_W-1:0]   max_live,

    output int                      mismatches,
    output int                      verdicts_owed,
    output int                      verdicts_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // page counters stop at the block size, or at what 6 bits can hold
    localparam int CNT_MAX = (PAGES_PER_BLOCK < 63) ? PAGES_PER_BLOCK : 63;

    // predicted selector state
    logic [CNT_W-1:0]   live_limit;
    logic [CNT_W-1:0]   blk_live;
    logic [CNT_W-1:0]   blk_reclaim;
    logic               blk_barred;
    logic               best_ok;
    logic [BLK_W-1:0]   best_idx;
    logic [CNT_W-1:0]   best_live_cnt;
    logic [CNT_W-1:0]   best_reclaim_cnt;
    logic [ERASE_W-1:0] best_wear;
    result_t            verdicts_due[$];

    item_t              seen_beat;

    assign seen_beat = {block_index, page_state, block_is_data, block_is_full,
                        erase_count, last_page, last_block};

    initial
    begin
        mismatches       = 0;
        verdicts_owed    = 0;
        verdicts_checked = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (int'(v) < CNT_MAX) ? v + 1'b1 : v;
    endfunction

    task automatic clear_block();
        blk_live    = '0;
        blk_reclaim = '0;
        blk_barred  = 1'b0;
    endtask

    task automatic clear_scan();
        clear_block();
        best_ok          = 1'b0;
        best_idx         = '0;
        best_live_cnt    = '0;
        best_reclaim_cnt = '0;
        best_wear        = '0;
    endtask

    // one accepted page beat: count, settle the block at its end, rule at scan end
    task automatic tally_beat(input item_t b);
        logic    eligible;
        logic    take;
        result_t pick;
        case (b.page_state)
            PS_FREE: ;
            PS_LIVE: blk_live = bump(blk_live);
            PS_STALE, PS_ORPHAN: blk_reclaim = bump(blk_reclaim);
            default: blk_barred = 1'b1;
        endcase

        // flags, wear and index come from the beat that closes the block
        if (b.last_page || b.last_block)
        begin
            eligible = b.block_is_data && b.block_is_full && !blk_barred
                       && (int'(b.block_index) < NUM_BLOCKS);
            take = !best_ok || (blk_reclaim > best_reclaim_cnt)
                   || (blk_reclaim == best_reclaim_cnt && b.erase_count < best_wear)
                   || (blk_reclaim == best_reclaim_cnt && b.erase_count == best_wear
                       && b.block_index < best_idx);
            if (eligible && take)
            begin
                best_ok          = 1'b1;
                best_idx         = b.block_index;
                best_live_cnt    = blk_live;
                best_reclaim_cnt = blk_reclaim;
                best_wear        = b.erase_count;
            end
            clear_block();
        end

        if (b.last_block)
        begin
            pick = '0;
            if (!best_ok)
                pick.status = ST_NO_BLOCK;
            else if (best_reclaim_cnt == '0)
                pick.status = ST_NOTHING;
            else if (best_live_cnt > live_limit)
                pick.status = ST_TOO_LIVE;
            else
            begin
                pick.status        = ST_VICTIM;
                pick.chosen_block  = best_idx;
                pick.live_count    = best_live_cnt;
                pick.reclaim_count = best_reclaim_cnt;
            end
            verdicts_due.push_back(pick);
            clear_scan();
        end
    endtask

    // one accepted result beat against the oldest verdict waiting
    task automatic check_result();
        result_t want;
        verdicts_checked++;
        if (verdicts_due.size() == 0)
        begin
            report_mismatch("result beat with no scan end waiting, status", int'(status), -1);
        end
        else
        begin
            want = verdicts_due.pop_front();
            if (status !== want.status)
                report_mismatch("status", int'(status), int'(want.status));
            if (chosen_block !== want.chosen_block)
                report_mismatch("chosen_block", int'(chosen_block), int'(want.chosen_block));
            if (live_count !== want.live_count)
                report_mismatch("live_count", int'(live_count), int'(want.live_count));
            if (reclaim_count !== want.reclaim_count)
                report_mismatch("reclaim_count", int'(reclaim_count),
                                int'(want.reclaim_count));
        end
    endtask

    // sample all channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_limit = MAX_LIVE_RESET;
            clear_scan();
            verdicts_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (cfg_valid && cfg_ready)
                live_limit = max_live;
            if (in_valid && !in_stall)
                tally_beat(seen_beat);
        end
        verdicts_owed = verdicts_due.size();
    end

endmodule : gcvs_victim_checker

/* tb/sv/testbench.sv */
// testbench: drives page-state scans and live-limit writes into gc_victim_block_select_top
// with random gaps and output stalls, and reports the verdict of gcvs_victim_checker.
// Depends on gcvs_pkg, gc_victim_block_select_top and gcvs_victim_checker.

module testbench
    import gcvs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 50;

    // page states that bar a block
    localparam logic [PS_W-1:0] PS_PINNED     = 3'd4;
    localparam logic [PS_W-1:0] PS_PENDING    = 3'd5;
    localparam logic [PS_W-1:0] PS_SRC_PINNED = 3'd6;
    localparam logic [PS_W-1:0] PS_STAGED     = 3'd7;

    typedef enum int {
        SCAN_CLEAN,
        SCAN_ROUGH,
        SCAN_NOISE,
        SCAN_LONG
    } scan_kind_t;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;

    logic               in_valid      = 1'b0;
    logic               in_stall;
    logic [BLK_W-1:0]   block_index   = '0;
    logic [PS_W-1:0]    page_state    = '0;
    logic               block_is_data = 1'b0;
    logic               block_is_full = 1'b0;
    logic [ERASE_W-1:0] erase_count   = '0;
    logic               last_page     = 1'b0;
    logic               last_block    = 1'b0;

    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [BLK_W-1:0]   chosen_block;
    logic [CNT_W-1:0]   live_count;
    logic [CNT_W-1:0]   reclaim_count;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CNT_W-1:0]   max_live  = MAX_LIVE_RESET;

    int                 mismatches;
    int                 verdicts_owed;
    int                 verdicts_checked;

    logic               calm      = 1'b0;
    logic               hold_req  = 1'b0;
    int                 hold_left = 0;
    int                 cycles    = 0;
    int                 beats_sent = 0;
    int                 scans_sent = 0;
    int                 limits_set = 0;

    gc_victim_block_select_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .block_index       (block_index),
        .page_state        (page_state),
        .block_is_data     (block_is_data),
        .block_is_full     (block_is_full),
        .erase_count       (erase_count),
        .last_page         (last_page),
        .last_block        (last_block),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .chosen_block      (chosen_block),
        .live_count        (live_count),
        .reclaim_count     (reclaim_count),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .max_live          (max_live)
    );

    gcvs_victim_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .block_index       (block_index),
        .page_state        (page_state),
        .block_is_data     (block_is_data),
        .block_is_full     (block_is_full),
        .erase_count       (erase_count),
        .last_page         (last_page),
        .last_block        (last_block),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .chosen_block      (chosen_block),
        .live_count        (live_count),
        .reclaim_count     (reclaim_count),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .max_live          (max_live),
        .mismatches        (mismatches),
        .verdicts_owed     (verdicts_owed),
        .verdicts_checked  (verdicts_checked)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d verdicts still owed", cycles, verdicts_owed);
            $display("gc_victim_block_select_top: mismatch");
            $finish;
        end
    end

    // result receiver: random stalls, or a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 33);
    end

    // offer one beat after an optional gap; hold it until accepted
    task automatic send_beat(input item_t b);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 20)
            gap = $urandom_range(1, 4);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        block_index   <= b.block_index;
        page_state    <= b.page_state;
        block_is_data <= b.block_is_data;
        block_is_full <= b.block_is_full;
        erase_count   <= b.erase_count;
        last_page     <= b.last_page;
        last_block    <= b.last_block;
        do @(posedge clk); while (in_stall);
        beats_sent++;
        if (b.last_block)
            scans_sent++;
    endtask

    task automatic page(input int blk, input logic [PS_W-1:0] ps, input logic data,
                        input logic full, input int wear, input logic lp, input logic lb);
        item_t b;
        b.block_index   = BLK_W'(blk);
        b.page_state    = ps;
        b.block_is_data = data;
        b.block_is_full = full;
        b.erase_count   = ERASE_W'(wear);
        b.last_page     = lp;
        b.last_block    = lb;
        send_beat(b);
    endtask

    // drop valid, let every result drain, then give the block time to go idle
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (verdicts_owed == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(input int v);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        max_live  <= CNT_W'(v);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        limits_set++;
    endtask

    function automatic logic [PS_W-1:0] pick_state();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            case ($urandom_range(0, 3))
                0: return PS_PINNED;
                1: return PS_PENDING;
                2: return PS_SRC_PINNED;
                default: return PS_STAGED;
            endcase
        end
        else if (r < 24)
            return PS_FREE;
        else if (r < 60)
            return PS_LIVE;
        else if (r < 82)
            return PS_STALE;
        return PS_ORPHAN;
    endfunction

    // small wear values make ties common
    function automatic int pick_wear();
        return ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
    endfunction

    // one scan of the given flavor, always closed by a last_block beat
    task automatic send_scan(input scan_kind_t kind);
        item_t b;
        int    nblk;
        int    npg;
        int    blk;
        bit    lean_live;
        int    k;
        int    p;
        if (kind == SCAN_NOISE)
        begin
            npg = $urandom_range(1, 6);
            for (p = 0; p < npg; p++)
            begin
                b.block_index   = BLK_W'($urandom_range(0, 15));
                b.page_state    = PS_W'($urandom_range(0, 7));
                b.block_is_data = $urandom_range(0, 1);
                b.block_is_full = $urandom_range(0, 1);
                b.erase_count   = ERASE_W'($urandom_range(0, 65535));
                b.last_page     = $urandom_range(0, 1);
                b.last_block    = (p == npg - 1);
                send_beat(b);
            end
            return;
        end

        nblk      = $urandom_range(1, 4);
        blk       = $urandom_range(0, 6);
        lean_live = $urandom_range(0, 1);
        for (k = 0; k < nblk; k++)
        begin
            npg = (kind == SCAN_LONG && k == 0) ? $urandom_range(34, 40) : $urandom_range(1, 5);
            b.block_index   = BLK_W'(blk);
            b.block_is_data = ($urandom_range(0, 99) < 85);
            b.block_is_full = ($urandom_range(0, 99) < 85);
            b.erase_count   = ERASE_W'(pick_wear());
            for (p = 0; p < npg; p++)
            begin
                if (kind == SCAN_LONG && k == 0)
                begin
                    if ($urandom_range(0, 99) < 90)
                        b.page_state = lean_live ? PS_LIVE : PS_STALE;
                    else
                        b.page_state = lean_live ? PS_STALE : PS_ORPHAN;
                end
                else
                    b.page_state = pick_state();
                b.last_page  = (p == npg - 1);
                b.last_block = (k == nblk - 1) && (p == npg - 1);
                // broken scans: flags drift between pages, block ends go missing or appear early
                if (kind == SCAN_ROUGH)
                begin
                    if (p != npg - 1)
                    begin
                        b.block_is_data = $urandom_range(0, 1);
                        b.block_is_full = $urandom_range(0, 1);
                        b.erase_count   = ERASE_W'(pick_wear());
                        b.last_page     = ($urandom_range(0, 3) == 0);
                    end
                    else if ($urandom_range(0, 99) < 30)
                        b.last_page = 1'b0;
                end
                send_beat(b);
            end
            blk = (kind == SCAN_ROUGH) ? $urandom_range(0, 15) : blk + $urandom_range(1, 2);
        end
    endtask

    // corner scans, one or a few beats each
    task automatic run_directed();
        logic [PS_W-1:0] barred[4];
        int              k;
        barred[0] = PS_PINNED;
        barred[1] = PS_PENDING;
        barred[2] = PS_SRC_PINNED;
        barred[3] = PS_STAGED;

        // lone stale page, top wear count
        page(0, PS_STALE, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1);
        // scan end closes the block without last_page
        page(15, PS_ORPHAN, 1'b1, 1'b1, 0, 1'b0, 1'b1);
        // not a data block, then not full
        page(3, PS_STALE, 1'b0, 1'b1, 7, 1'b1, 1'b1);
        page(4, PS_STALE, 1'b1, 1'b0, 7, 1'b1, 1'b1);
        // each barring state knocks out its block
        for (k = 0; k < 4; k++)
        begin
            page(k + 1, PS_STALE, 1'b1, 1'b1, 1, 1'b0, 1'b0);
            page(k + 1, barred[k], 1'b1, 1'b1, 1, 1'b1, k == 3);
        end
        // eligible but nothing to reclaim
        page(6, PS_FREE, 1'b1, 1'b1, 9, 1'b0, 1'b0);
        page(6, PS_LIVE, 1'b1, 1'b1, 9, 1'b1, 1'b1);
        // ties: lower wear wins, higher index loses, out-of-order lower index wins
        page(2, PS_STALE, 1'b1, 1'b1, 5, 1'b1, 1'b0);
        page(3, PS_STALE, 1'b1, 1'b1, 3, 1'b1, 1'b0);
        page(4, PS_STALE, 1'b1, 1'b1, 3, 1'b1, 1'b0);
        page(1, PS_ORPHAN, 1'b1, 1'b1, 3, 1'b1, 1'b1);
        // flags on the early page do not count
        page(8, PS_STALE, 1'b0, 1'b0, 100, 1'b0, 1'b0);
        page(8, PS_LIVE, 1'b1, 1'b1, 2, 1'b1, 1'b1);
        // live limit of zero refuses any live page
        set_limit(0);
        page(9, PS_LIVE, 1'b1, 1'b1, 4, 1'b0, 1'b0);
        page(9, PS_STALE, 1'b1, 1'b1, 4, 1'b1, 1'b1);
    endtask

    // receiver holds off while short scans keep coming, so the input backs up
    task automatic press_output();
        int k;
        @(negedge clk);
        hold_req = 1'b1;
        for (k = 0; k < 6; k++)
            page($urandom_range(0, 15), PS_STALE, 1'b1, 1'b1, pick_wear(), 1'b1, 1'b1);
    endtask

    initial
    begin
        int         ph;
        int         start;
        int         r;
        bit         paused;
        scan_kind_t kind;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        paused = 1'b0;
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_limit(32);
                1: set_limit(31);
                2: set_limit(25);
                3: set_limit(1);
                4: set_limit(0);
                default: set_limit($urandom_range(0, 32));
            endcase
            calm = (ph == 2);
            if (ph == 3)
                press_output();
            start = beats_sent;
            while (beats_sent - start < PHASE_BEATS)
            begin
                // sender waits out every result once, mid-phase
                if (ph == 5 && !paused && beats_sent - start >= PHASE_BEATS / 2)
                begin
                    @(negedge clk);
                    in_valid <= 1'b0;
                    wait (verdicts_owed == 0);
                    paused = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 72)
                    kind = SCAN_CLEAN;
                else if (r < 86)
                    kind = SCAN_ROUGH;
                else if (r < 95)
                    kind = SCAN_NOISE;
                else
                    kind = SCAN_LONG;
                send_scan(kind);
            end
            calm = 1'b0;
        end

        settle();
        repeat (4 * DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d scans over %0d page beats, %0d verdicts compared",
                 scans_sent, beats_sent, verdicts_checked);
        $display("live-page limit set %0d times, with output hold-off and drained pauses",
                 limits_set);
        if (mismatches == 0)
            $display("gc_victim_block_select_top: match");
        else
            $display("gc_victim_block_select_top: mismatch");
        $finish;
    end

endmodule : testbench

/* gc_victim_block_select_top.f */
rtl/gcvs_pkg.sv
rtl/gcvs_scan_core.sv
rtl/gc_victim_block_select_top.sv
tb/sv/gcvs_victim_checker.sv
tb/sv/testbench.sv
